[hdl/t3d_pkg.sv]
// ----------------------------------------------------------------------------
// t3d_pkg - shared types and constants for the 3D turtle pose engine
// Holds opcodes, status codes, controller states, the arctangent table and
// the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package t3d_pkg;

  localparam int STACK_DEPTH  = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
  localparam int SLOT_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int STEP_W = $clog2(CORDIC_STEPS + 1);

  typedef enum logic [2:0] {
    OP_MOVE    = 3'd0,
    OP_ROTX    = 3'd1,
    OP_ROTY    = 3'd2,
    OP_ROTZ    = 3'd3,
    OP_PUSH    = 3'd4,
    OP_POP     = 3'd5,
    OP_RESTART = 3'd6,
    OP_NOP     = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVFL  = 2'd1,
    ST_UNFL  = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CORDIC,
    S_MUL,
    S_COMB,
    S_POPRD,
    S_POPWR,
    S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // latch the request
    logic cordic_run; // one CORDIC iteration
    logic mul;        // register products
    logic comb;       // write back op result
    logic pop_wr;     // restore pose from stack read data
    logic out_load;   // present result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic    cordic_done;
    opcode_t op;
    logic    full;
    logic    empty;
  } dp_sts_t;

  localparam logic [31:0] CORDIC_X0 = 32'd652032874;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;  5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;  5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;  5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;  5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

[hdl/t3d_ctrl.sv]
// ----------------------------------------------------------------------------
// t3d_ctrl - command sequencer
// Steps each request through CORDIC, product, combine, stack and output
// phases and drives the datapath by a command struct.
// ----------------------------------------------------------------------------
module t3d_ctrl import t3d_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_fire,
  input  logic    out_busy,
  output logic    in_rdy,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  state_t state_r, state_nxt;

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequence one request
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_rdy    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_rdy = 1'b1;
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = S_CORDIC;
        end
      end
      S_CORDIC: begin
        priority if (sts.op == OP_ROTX || sts.op == OP_ROTY ||
                     sts.op == OP_ROTZ) begin
          if (sts.cordic_done) begin
            state_nxt = S_MUL;
          end else begin
            cmd.cordic_run = 1'b1;
          end
        end else if (sts.op == OP_POP && !sts.empty) begin
          state_nxt = S_POPRD;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_COMB;
      end
      S_COMB: begin
        cmd.comb  = 1'b1;
        state_nxt = S_OUT;
      end
      S_POPRD: begin
        state_nxt = S_POPWR;
      end
      S_POPWR: begin
        cmd.pop_wr = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[hdl/t3d_dp.sv]
// ----------------------------------------------------------------------------
// t3d_dp - pose datapath
// Pose registers, CORDIC unit, product registers, saturating combine and
// the pose stack memory.
// ----------------------------------------------------------------------------
module t3d_dp import t3d_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic [2:0]         req_op,
  input  logic signed [31:0] req_amt,
  input  logic signed [31:0] start_pos [3],
  input  logic signed [15:0] start_head [3],
  output logic [143:0]       pose,
  output logic [1:0]         res_status
);

  logic signed [31:0] pos_r  [3];
  logic signed [15:0] head_r [3];
  logic [LVL_W-1:0]   lvl_r;
  opcode_t            op_r;
  logic signed [31:0] amt_r;
  logic [1:0]         stat_r;

  // CORDIC state
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic               flip_r;
  logic [STEP_W-1:0]  step_r;

  // products: three position, four heading
  logic signed [47:0] pp_r [3];
  logic signed [31:0] hp_r [4];

  // stack memory, one pose per entry
  logic [143:0] stk_mem [STACK_DEPTH];
  logic [143:0] stk_rd_r;

  logic signed [15:0] cos_v, sin_v, nsin_v;
  logic signed [33:0] xs, ys;
  logic [31:0]        ang;
  logic [SLOT_W-1:0]  wr_slot, rd_slot;
  logic signed [17:0] cr, sr;

  assign sts.op          = op_r;
  assign sts.cordic_done = (step_r == STEP_W'(CORDIC_STEPS));
  assign sts.full        = (lvl_r == LVL_W'(STACK_DEPTH));
  assign sts.empty       = (lvl_r == '0);

  assign ang = {req_amt[15:0], 16'h0};
  assign xs  = cx_r >>> step_r;
  assign ys  = cy_r >>> step_r;

  // round cos/sin to Q2.14, flip for the far half turn
  assign cr     = 18'((flip_r ? -cx_r : cx_r) + 34'sd32768 >>> 16);
  assign sr     = 18'((flip_r ? -cy_r : cy_r) + 34'sd32768 >>> 16);
  assign cos_v  = cr[15:0];
  assign sin_v  = sr[15:0];
  assign nsin_v = -sin_v;

  assign wr_slot = lvl_r[SLOT_W-1:0];
  assign rd_slot = SLOT_W'(lvl_r - LVL_W'(1));

  function automatic logic signed [15:0] sat16(input logic signed [32:0] v);
    logic signed [32:0] r;
    r = (v + 33'sd8192) >>> 14;
    if (r > 33'sd32767)       return 16'sh7FFF;
    else if (r < -33'sd32768) return 16'sh8000;
    else                      return r[15:0];
  endfunction

  // latch request, run CORDIC iterations
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= opcode_t'(req_op);
      amt_r  <= req_amt;
      step_r <= '0;
      cx_r   <= 34'(CORDIC_X0);
      cy_r   <= '0;
      flip_r <= (ang[31:30] == 2'd1 || ang[31:30] == 2'd2);
      cz_r   <= (ang[31:30] == 2'd1 || ang[31:30] == 2'd2) ?
                34'(signed'(ang + 32'h80000000)) : 34'(signed'(ang));
    end else if (cmd.cordic_run) begin
      step_r <= step_r + STEP_W'(1);
      if (!cz_r[33]) begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - 34'(atan_lut(5'(step_r)));
      end else begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + 34'(atan_lut(5'(step_r)));
      end
    end
  end

  // register products
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      for (int k = 0; k < 3; k++) begin
        pp_r[k] <= amt_r * head_r[k];
      end
      unique case (op_r)
        OP_ROTX: begin
          hp_r[0] <= head_r[1] * cos_v;  hp_r[1] <= head_r[2] * sin_v;
          hp_r[2] <= head_r[1] * nsin_v; hp_r[3] <= head_r[2] * cos_v;
        end
        OP_ROTY: begin
          hp_r[0] <= head_r[0] * cos_v;  hp_r[1] <= head_r[2] * nsin_v;
          hp_r[2] <= head_r[0] * sin_v;  hp_r[3] <= head_r[2] * cos_v;
        end
        default: begin
          hp_r[0] <= head_r[0] * cos_v;  hp_r[1] <= head_r[1] * sin_v;
          hp_r[2] <= head_r[0] * nsin_v; hp_r[3] <= head_r[1] * cos_v;
        end
      endcase
    end
  end

  // stack memory write and read
  always_ff @(posedge clk) begin
    if (cmd.comb && op_r == OP_PUSH && !sts.full) begin
      stk_mem[wr_slot] <= {pos_r[2], pos_r[1], pos_r[0],
                           head_r[2], head_r[1], head_r[0]};
    end
    stk_rd_r <= stk_mem[rd_slot];
  end

  // update pose
  always_ff @(posedge clk) begin
    logic signed [34:0] p;
    logic signed [15:0] h0, h1;
    logic               sat;
    sat = 1'b0;
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) pos_r[k] <= '0;
      head_r[0] <= '0;
      head_r[1] <= '0;
      head_r[2] <= 16'sd16384;
      lvl_r     <= '0;
      stat_r    <= ST_OK;
    end else if (cmd.load) begin
      stat_r <= ST_OK;
    end else if (cmd.pop_wr) begin
      lvl_r <= lvl_r - LVL_W'(1);
      for (int k = 0; k < 3; k++) begin
        pos_r[k]  <= stk_rd_r[48+32*k +: 32];
        head_r[k] <= stk_rd_r[16*k +: 16];
      end
    end else if (cmd.comb) begin
      h0 = sat16(33'(hp_r[0]) + 33'(hp_r[1]));
      h1 = sat16(33'(hp_r[2]) + 33'(hp_r[3]));
      unique case (op_r)
        OP_MOVE: begin
          for (int k = 0; k < 3; k++) begin
            p = 35'(pos_r[k]) + 35'((pp_r[k] + 48'sd8192) >>> 14);
            if (p > 35'sd2147483647) begin
              pos_r[k] <= 32'sh7FFFFFFF; sat = 1'b1;
            end else if (p < -35'sd2147483648) begin
              pos_r[k] <= 32'sh80000000; sat = 1'b1;
            end else begin
              pos_r[k] <= p[31:0];
            end
          end
          if (sat) stat_r <= ST_SAT;
        end
        OP_ROTX: begin head_r[1] <= h0; head_r[2] <= h1; end
        OP_ROTY: begin head_r[0] <= h0; head_r[2] <= h1; end
        OP_ROTZ: begin head_r[0] <= h0; head_r[1] <= h1; end
        OP_PUSH: begin
          if (sts.full) stat_r <= ST_OVFL;
          else          lvl_r  <= lvl_r + LVL_W'(1);
        end
        OP_POP:  stat_r <= ST_UNFL;
        OP_RESTART: begin
          for (int k = 0; k < 3; k++) begin
            pos_r[k]  <= start_pos[k];
            head_r[k] <= start_head[k];
          end
        end
        default: ;
      endcase
    end
  end

  assign pose = {head_r[2], head_r[1], head_r[0], pos_r[2], pos_r[1], pos_r[0]};
  assign res_status = stat_r;

endmodule

[hdl/turtle_3d_pose_engine.sv]
// ----------------------------------------------------------------------------
// turtle_3d_pose_engine - 3D turtle command interpreter
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_ stream: opcode in in_tdata[2:0], amount in
//   in_tdata[34:3]. Each request gives exactly one result on the out_ stream:
//   pos x/y/z (Q16.16), heading x/y/z (Q2.14) and a two-bit status.
//   The start pose for restart is written over the cfg_ APB port.
//   One request is in flight at a time. A rotation runs 16 CORDIC iterations,
//   a done check, product, combine and output load; move, push, restart,
//   the spare opcode and a pop on an empty stack skip the iterations, and a
//   pop with data reads the stack and writes the pose back before output load.
//   A new request is accepted only once the sequencer is back in idle.
//   The result sits in an output register; the next request is accepted
//   while it waits, and the sequencer holds before writing a new result
//   until out_tready takes the old one.
//   Reset clears the pose to the origin heading +z, empties the pose stack
//   and restores the start registers; stack contents are not cleared.
// ----------------------------------------------------------------------------
module turtle_3d_pose_engine import t3d_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // opcode[2:0], amount[34:3], zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [151:0] out_tdata,  // pos_x,pos_y,pos_z,head_x,head_y,head_z,status,pad
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam logic [2:0] R_PX = 3'd0, R_PY = 3'd1, R_PZ = 3'd2,
                         R_HX = 3'd3, R_HY = 3'd4, R_HZ = 3'd5;

  logic signed [31:0] spos_r  [3];
  logic signed [15:0] shead_r [3];
  dp_cmd_t            cmd;
  dp_sts_t            sts;
  logic [143:0]       pose;
  logic [1:0]         res_status;
  logic [151:0]       out_data_r;
  logic               out_vld_r;
  logic               in_rdy;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  // write start pose registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) spos_r[k] <= '0;
      shead_r[0] <= '0;
      shead_r[1] <= '0;
      shead_r[2] <= 16'sd16384;
    end else if (cfg_wr && cfg_paddr[1:0] == 2'b00) begin
      unique case (cfg_paddr[4:2])
        R_PX: spos_r[0]  <= cfg_pwdata;
        R_PY: spos_r[1]  <= cfg_pwdata;
        R_PZ: spos_r[2]  <= cfg_pwdata;
        R_HX: shead_r[0] <= cfg_pwdata[15:0];
        R_HY: shead_r[1] <= cfg_pwdata[15:0];
        R_HZ: shead_r[2] <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (cfg_paddr[4:2])
      R_PX: cfg_prdata = spos_r[0];
      R_PY: cfg_prdata = spos_r[1];
      R_PZ: cfg_prdata = spos_r[2];
      R_HX: cfg_prdata = 32'(shead_r[0]);
      R_HY: cfg_prdata = 32'(shead_r[1]);
      R_HZ: cfg_prdata = 32'(shead_r[2]);
      default: cfg_prdata = '0;
    endcase
  end

  assign in_tready = in_rdy;

  t3d_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_tvalid & in_rdy),
    .out_busy (out_vld_r & ~out_tready),
    .in_rdy   (in_rdy),
    .cmd      (cmd),
    .sts      (sts)
  );

  t3d_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .req_op     (in_tdata[2:0]),
    .req_amt    (in_tdata[34:3]),
    .start_pos  (spos_r),
    .start_head (shead_r),
    .pose       (pose),
    .res_status (res_status)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {6'd0, res_status, pose};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |-> !cmd.out_load)
    else $error("result overwritten while stalled");

  // a request is only taken with the sequencer idle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !in_tready)
    else $error("second request taken while busy");

  // valid is high in the cycle after the result register loads
  a_valid_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_tvalid)
    else $error("result not presented");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the 3D turtle pose engine
// Drives turtle commands on the in_ stream, predicts each pose and status in
// a bit-accurate model of the engine, and compares every out_ result in
// order. Start-pose registers are rewritten over APB between phases, and
// both stream sides idle and stall at random with varying duty.
// ----------------------------------------------------------------------------
module testbench;
  import t3d_pkg::*;

  typedef struct packed {
    logic [31:0] amount;
    opcode_t     op;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] hz;
    logic [15:0] hy;
    logic [15:0] hx;
    logic [31:0] pz;
    logic [31:0] py;
    logic [31:0] px;
  } pose_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [39:0]  in_tdata;   // opcode[2:0], amount[34:3], zero pad
  logic         out_tvalid;
  logic         out_tready;
  logic [151:0] out_tdata;  // pos_x, pos_y, pos_z, head_x, head_y, head_z, status, pad
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [4:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  turtle_3d_pose_engine u_dut (.*);

  // Turtle model state
  logic signed [31:0] pos [3];
  logic signed [15:0] head [3];
  logic signed [31:0] saved_pos [3*STACK_DEPTH];
  logic signed [15:0] saved_head [3*STACK_DEPTH];
  int                 depth_used;
  logic [31:0]        start_pos [3];
  logic [15:0]        start_head [3];

  cmd_t   pending_cmds [$];
  pose_t  expected_poses [$];
  int     in_idle_pct;
  int     out_stall_pct;
  logic   holding;
  int     mismatches;
  int     poses_checked;
  int     n_sat, n_ovfl, n_unfl;
  logic   stim_done;

  // Clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic longint asr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Fixed-length CORDIC, rotation mode, with half-turn folding
  task automatic sin_cos(input logic [15:0] ang, output longint c, output longint s);
    logic [31:0] a;
    logic        flip;
    longint      x, y, z, xs, ys;
    a    = {ang, 16'h0};
    flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
    if (flip) a = a + 32'h8000_0000;
    x = 652032874;
    y = 0;
    z = longint'($signed(a));
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = asr(x, i);
      ys = asr(y, i);
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - longint'(atan_lut(i[4:0]));
      end else begin
        x = x + ys; y = y - xs; z = z + longint'(atan_lut(i[4:0]));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = asr(x + 32768, 16);
    s = asr(y + 32768, 16);
  endtask

  function automatic logic [15:0] mix(longint a, longint ka, longint b, longint kb);
    return 16'(clip(asr(a * ka + b * kb + 8192, 14), -32768, 32767));
  endfunction

  // Advance the turtle by one command and return the pose it reports
  task automatic turtle_step(input cmd_t cmd, output pose_t r);
    longint  c, s, hx, hy, hz, d, p, q, amt;
    status_t st;
    st  = ST_OK;
    hx  = head[0]; hy = head[1]; hz = head[2];
    amt = longint'($signed(cmd.amount));
    case (cmd.op)
      OP_MOVE: begin
        for (int k = 0; k < 3; k++) begin
          d = asr(amt * longint'(head[k]) + 8192, 14);
          p = longint'(pos[k]) + d;
          q = clip(p, -64'sd2147483648, 64'sd2147483647);
          if (q != p) st = ST_SAT;
          pos[k] = 32'(q);
        end
      end
      OP_ROTX: begin
        sin_cos(cmd.amount[15:0], c, s);
        head[1] = mix(hy, c, hz, s);
        head[2] = mix(hy, -s, hz, c);
      end
      OP_ROTY: begin
        sin_cos(cmd.amount[15:0], c, s);
        head[0] = mix(hx, c, hz, -s);
        head[2] = mix(hx, s, hz, c);
      end
      OP_ROTZ: begin
        sin_cos(cmd.amount[15:0], c, s);
        head[0] = mix(hx, c, hy, s);
        head[1] = mix(hx, -s, hy, c);
      end
      OP_PUSH: begin
        if (depth_used >= STACK_DEPTH) begin
          st = ST_OVFL;
        end else begin
          for (int k = 0; k < 3; k++) begin
            saved_pos[depth_used*3+k]  = pos[k];
            saved_head[depth_used*3+k] = head[k];
          end
          depth_used++;
        end
      end
      OP_POP: begin
        if (depth_used == 0) begin
          st = ST_UNFL;
        end else begin
          depth_used--;
          for (int k = 0; k < 3; k++) begin
            pos[k]  = saved_pos[depth_used*3+k];
            head[k] = saved_head[depth_used*3+k];
          end
        end
      end
      OP_RESTART: begin
        for (int k = 0; k < 3; k++) begin
          pos[k]  = start_pos[k];
          head[k] = start_head[k];
        end
      end
      default: ;
    endcase
    if (st == ST_SAT) n_sat++;
    if (st == ST_OVFL) n_ovfl++;
    if (st == ST_UNFL) n_unfl++;
    r = '{status: st, hz: head[2], hy: head[1], hx: head[0],
          pz: pos[2], py: pos[1], px: pos[0]};
  endtask

  // Driver: offer queued commands, hold an offer until taken, idle at random
  always @(posedge clk) begin
    cmd_t  nxt;
    pose_t r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        turtle_step(cmd_t'(in_tdata[34:0]), r);
        expected_poses.push_back(r);
        void'(pending_cmds.pop_front());
      end
      if (!in_tvalid || in_tready) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
          nxt = pending_cmds[0];
          in_tvalid <= 1'b1;
          in_tdata  <= {5'b0, nxt};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare results in order, stall at random or hold off
  always @(posedge clk) begin
    pose_t got, exp_p;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = pose_t'(out_tdata[145:0]);
        poses_checked++;
        if (expected_poses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          exp_p = expected_poses.pop_front();
          if (got !== exp_p) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp px %h py %h pz %h hx %h hy %h hz %h st %0d",
                       exp_p.px, exp_p.py, exp_p.pz, exp_p.hx, exp_p.hy, exp_p.hz,
                       exp_p.status, "\n          got px %h py %h pz %h hx %h hy %h hz %h st %0d",
                       got.px, got.py, got.pz, got.hx, got.hy, got.hz, got.status);
          end
        end
      end
      if (holding) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  // APB register write, setup then access
  task automatic reg_write(input int idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= 5'(4 * idx); cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (idx < 3) start_pos[idx] = val;
    else start_head[idx-3] = val[15:0];
  endtask

  task automatic drain();
    while (pending_cmds.size() > 0 || expected_poses.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic add_cmd(input opcode_t op, input logic [31:0] amt);
    pending_cmds.push_back('{amount: amt, op: op});
  endtask

  // Random command, mostly well-formed; stack ops kept near balance
  task automatic add_random(input int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 30)
        add_cmd(OP_MOVE, ($urandom_range(9) == 0) ? $urandom
                         : 32'($signed($urandom_range(262144)) - 131072));
      else if (pick < 60)
        add_cmd(opcode_t'($urandom_range(3, 1)), $urandom);
      else if (pick < 75) add_cmd(OP_PUSH, $urandom);
      else if (pick < 90) add_cmd(OP_POP, $urandom);
      else if (pick < 97) add_cmd(OP_RESTART, $urandom);
      else add_cmd(OP_NOP, $urandom);
    end
  endtask

  // Start-pose setting: random pose with heading components within +-1.0, or extremes
  task automatic set_start(input int mode);
    logic [31:0] v;
    for (int k = 0; k < 6; k++) begin
      case (mode)
        0: v = (k < 3) ? 32'h8000_0000 : 32'h0000_8000;
        1: v = (k < 3) ? 32'h7FFF_FFFF : 32'h0000_7FFF;
        default: v = (k < 3) ? (($urandom_range(3) == 0) ? $urandom
                                 : 32'($signed($urandom_range(2000000)) - 1000000))
                             : {16'h0, 16'($signed($urandom_range(32768)) - 16384)};
      endcase
      reg_write(k, v);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; out_tready = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    in_idle_pct = 0; out_stall_pct = 0; holding = 1'b0;
    mismatches = 0; poses_checked = 0; n_sat = 0; n_ovfl = 0; n_unfl = 0;
    stim_done = 1'b0;
    for (int k = 0; k < 3; k++) begin
      pos[k] = '0; head[k] = '0; start_pos[k] = '0; start_head[k] = '0;
    end
    head[2] = 16384; start_head[2] = 16384; depth_used = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: underflow, moves, every rotation, restart, stack overflow
    add_cmd(OP_POP, 32'h0);
    add_cmd(OP_MOVE, 32'h0001_0000);
    add_cmd(OP_MOVE, 32'h7FFF_FFFF);
    add_cmd(OP_MOVE, 32'h7FFF_FFFF);
    add_cmd(OP_MOVE, 32'h8000_0000);
    add_cmd(OP_ROTX, 32'hFFFF_4000);
    add_cmd(OP_ROTY, 32'h0000_8000);
    add_cmd(OP_ROTZ, 32'h0000_C000);
    add_cmd(OP_ROTX, 32'h0000_FFFF);
    add_cmd(OP_ROTZ, 32'h0000_0000);
    add_cmd(OP_NOP, 32'hFFFF_FFFF);
    add_cmd(OP_RESTART, 32'h0);
    for (int i = 0; i < STACK_DEPTH + 1; i++) add_cmd(OP_PUSH, 32'h0);
    drain();

    // Extreme start poses, then a heavy-saturation burst
    set_start(0);
    add_cmd(OP_RESTART, 32'h0);
    add_cmd(OP_MOVE, 32'h7FFF_FFFF);
    add_cmd(OP_ROTY, 32'h0000_2000);
    add_random(100);
    drain();
    set_start(1);
    add_cmd(OP_RESTART, 32'h0);
    add_cmd(OP_MOVE, 32'h8000_0000);
    for (int i = 0; i < STACK_DEPTH; i++) add_cmd(OP_POP, 32'h0);
    add_random(100);
    drain();

    // Random phases with different idle and stall mixes
    for (int ph = 0; ph < 5; ph++) begin
      set_start(2);
      case (ph)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 85; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 85; end
        3: begin in_idle_pct = 20; out_stall_pct = 20; end
        default: begin in_idle_pct = 0; out_stall_pct = 0; end
      endcase
      add_random(190);
      // long receiver hold-off while commands keep coming
      if (ph == 4) begin
        fork
          begin
            holding = 1'b1;
            repeat (400) @(posedge clk);
            holding = 1'b0;
          end
        join_none
      end
      drain();
    end
    stim_done = 1'b1;

    $display("covered %0d results: %0d saturations, %0d stack overflows, %0d underflows",
             poses_checked, n_sat, n_ovfl, n_unfl);
    $display("start pose rewritten over 7 settings under 5 handshake mixes");
    if (mismatches == 0 && expected_poses.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Timeout
  initial begin
    #5ms;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
